// ===== rtl/fwsm_pkg.sv =====
// fwsm_pkg: shared types and constants for the four-way stack manager
// no dependencies; imported by every rtl file of the block
package fwsm_pkg;

  // default sizing of the stack set
  localparam int NumStacksDef  = 4;
  localparam int StackDepthDef = 1024;

  // fixed field widths
  localparam int OpW    = 2;
  localparam int SelW   = 2;
  localparam int ValueW = 30;
  localparam int WordW  = 32;

  // operation codes
  localparam logic [OpW-1:0] OP_PUSH  = 2'd0;
  localparam logic [OpW-1:0] OP_POP   = 2'd1;
  localparam logic [OpW-1:0] OP_CLEAR = 2'd2;

  // response word constants
  localparam logic [WordW-1:0] PUSH_OK = 32'hFFFF_FFFF;
  localparam logic [1:0]       POP_TAG = 2'b11;

  // command beat
  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [SelW-1:0]   stack_select;
    logic [ValueW-1:0] push_value;
  } cmd_t;

  // response beat
  typedef struct packed {
    logic              success;
    logic [ValueW-1:0] pop_value;
    logic [WordW-1:0]  response_word;
  } rsp_t;

endpackage

// ===== rtl/four_way_stack_manager.sv =====
// four_way_stack_manager: top level, command decode, stack counts and response register
// depends on fwsm_pkg and fwsm_store
//
//   channel | signals                      | beat
//   cmd     | cmd_valid, cmd_ready, cmd    | operation, stack_select, push_value
//   rsp     | rsp_valid, rsp_ready, rsp    | success, pop_value, response_word
//
// a command waits in a one-entry holding register and executes once the response
// register is free; push, clear and failed pop finish in the idle state, one beat per
// cycle if rsp flows; a successful pop adds a read state for the store's registered read port
// rst is synchronous: all counts go to zero at once, store contents stay undefined
// a held response does not block acceptance of the next command into the holding
// register; nothing executes while the response register is still occupied
module four_way_stack_manager #(
  parameter int NUM_STACKS  = fwsm_pkg::NumStacksDef,
  parameter int STACK_DEPTH = fwsm_pkg::StackDepthDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  fwsm_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output fwsm_pkg::rsp_t rsp
);
  import fwsm_pkg::*;

  localparam int ENTRIES = NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t            state;
  logic              pend;
  cmd_t              pend_cmd;
  logic [CNT_W-1:0]  cnt [NUM_STACKS];

  logic              exec;
  logic              sel_ok;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  cur_cnt;
  logic              is_push;
  logic              is_pop;
  logic              push_ok;
  logic              pop_ok;
  logic              rsp_load;
  logic [ADDR_W-1:0] base;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ValueW-1:0] rd_data;

  // execute when a command is held, no pop read is in flight and the response register is free
  assign exec      = pend && (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign cmd_ready = !pend || exec;

  // decode against the current count of the addressed stack
  assign sel_ok  = (32'(pend_cmd.stack_select) < NUM_STACKS);
  assign idx     = IDX_W'(pend_cmd.stack_select);
  assign cur_cnt = sel_ok ? cnt[idx] : '0;
  assign is_push = (pend_cmd.operation == OP_PUSH);
  assign is_pop  = (pend_cmd.operation == OP_POP);
  assign push_ok = sel_ok && (cur_cnt < CNT_W'(STACK_DEPTH));
  assign pop_ok  = sel_ok && (cur_cnt != '0);

  // a response beat is loaded by push, failed pop, or returning pop data
  assign rsp_load = (state == ST_READ) || (exec && (is_push || (is_pop && !pop_ok)));

  // store addressing: each stack owns a slice of STACK_DEPTH entries
  assign base    = ADDR_W'(pend_cmd.stack_select) * ADDR_W'(STACK_DEPTH);
  assign wr_addr = base + ADDR_W'(cur_cnt);
  assign rd_addr = base + ADDR_W'(cur_cnt - CNT_W'(1));
  assign wr_en   = exec && is_push && push_ok;
  assign rd_en   = exec && is_pop && pop_ok;

  fwsm_store #(
    .ENTRIES (ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (pend_cmd.push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // command holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      pend <= 1'b1;
    end else if (exec) begin
      pend <= 1'b0;
    end
    if (cmd_valid && cmd_ready) begin
      pend_cmd <= cmd;
    end
  end

  // sequencer, stack counts and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      rsp       <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      // response beat loads or retires
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (exec) begin
            case (pend_cmd.operation)
              OP_PUSH: begin
                rsp.success       <= push_ok;
                rsp.pop_value     <= '0;
                rsp.response_word <= push_ok ? PUSH_OK : '0;
                if (push_ok) begin
                  cnt[idx] <= cur_cnt + CNT_W'(1);
                end
              end
              OP_POP: begin
                if (pop_ok) begin
                  cnt[idx] <= cur_cnt - CNT_W'(1);
                  state    <= ST_READ;
                end else begin
                  rsp.success       <= 1'b0;
                  rsp.pop_value     <= '0;
                  rsp.response_word <= '0;
                end
              end
              OP_CLEAR: begin
                for (int i = 0; i < NUM_STACKS; i++) begin
                  cnt[i] <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          // store data for the pop is back
          rsp.success       <= 1'b1;
          rsp.pop_value     <= rd_data;
          rsp.response_word <= {POP_TAG, rd_data};
          state             <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/fwsm_store.sv =====
// fwsm_store: shared entry store, one write port and one registered read port
// depends on fwsm_pkg for the value width
module fwsm_store #(
  parameter int ENTRIES = 4096,
  parameter int ADDR_W  = 12
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [fwsm_pkg::ValueW-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [fwsm_pkg::ValueW-1:0] rd_data
);
  import fwsm_pkg::*;

  logic [ValueW-1:0] mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/fwsm_chk.sv =====
// fwsm_chk: port-level checks on the four-way stack manager, bound to the top level
// depends on fwsm_pkg and four_way_stack_manager
module fwsm_chk (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input fwsm_pkg::cmd_t cmd,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input fwsm_pkg::rsp_t rsp
);
  import fwsm_pkg::*;

  // a stalled response beat stays up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped while stalled");

  // a stalled response beat keeps its payload
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp))
    else $error("response payload changed while stalled");

  // a successful beat carries the tag bits
  a_ok_tag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.success |-> rsp.response_word[31:30] == POP_TAG)
    else $error("successful response without tag bits");

  // a failed beat is all zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.success |-> rsp.response_word == '0 && rsp.pop_value == '0)
    else $error("failed response not zero");

  // a successful pop echoes its value in the response word
  a_pop_echo: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.success && rsp.response_word != PUSH_OK
      |-> rsp.response_word[29:0] == rsp.pop_value)
    else $error("pop value and response word disagree");

endmodule

bind four_way_stack_manager fwsm_chk u_fwsm_chk (.*);

// ===== sim/four_way_stack_manager_test.sv =====
// four_way_stack_manager_test: self-checking testbench for the four-way stack manager
// depends on fwsm_pkg and the four_way_stack_manager rtl; stimulus is directed, then random
// command beats, each response beat checked against a shadow copy of the four stacks
`timescale 1ns / 100ps

module four_way_stack_manager_test;
  import fwsm_pkg::*;

  localparam int NumStacks  = NumStacksDef;
  localparam int StackDepth = StackDepthDef;
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
  localparam int DrainCycles = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  four_way_stack_manager u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 12 ns clock
  always #6 clk = ~clk;

  // command beats waiting to be offered, response beats waiting to arrive
  cmd_t cmd_pending[$];
  rsp_t reply_expected[$];

  // shadow copy of the stacks
  logic [ValueW-1:0] shadow_store [NumStacks][StackDepth];
  int unsigned       shadow_depth [NumStacks];

  int fail_count = 0;
  int beats_seen = 0;
  int n_push_ok = 0, n_push_full = 0, n_pop_ok = 0, n_pop_empty = 0;
  int n_clear = 0, n_ignored = 0;

  // apply one accepted command to the shadow stacks and queue its reply, if it has one
  function automatic void predict_reply(cmd_t c);
    rsp_t r;
    int   s;
    r = '0;
    s = int'(c.stack_select);
    case (c.operation)
      OP_PUSH: begin
        if (s < NumStacks && shadow_depth[s] < StackDepth) begin
          shadow_store[s][shadow_depth[s]] = c.push_value;
          shadow_depth[s]++;
          r.success       = 1'b1;
          r.response_word = PUSH_OK;
          n_push_ok++;
        end else begin
          n_push_full++;
        end
        reply_expected.push_back(r);
      end
      OP_POP: begin
        if (s < NumStacks && shadow_depth[s] > 0) begin
          shadow_depth[s]--;
          r.success       = 1'b1;
          r.pop_value     = shadow_store[s][shadow_depth[s]];
          r.response_word = {POP_TAG, r.pop_value};
          n_pop_ok++;
        end else begin
          n_pop_empty++;
        end
        reply_expected.push_back(r);
      end
      OP_CLEAR: begin
        for (int i = 0; i < NumStacks; i++) shadow_depth[i] = 0;
        n_clear++;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endfunction

  function automatic void queue_cmd(logic [OpW-1:0] op, logic [SelW-1:0] sel,
                                    logic [ValueW-1:0] val);
    cmd_t c;
    c.operation    = op;
    c.stack_select = sel;
    c.push_value   = val;
    cmd_pending.push_back(c);
  endfunction

  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ValueW'($urandom);
    endcase
  endfunction

  // mixed pushes and pops with the odd clear and unused code
  function automatic void add_random_mix(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 46)
        queue_cmd(OP_PUSH, SelW'($urandom), rand_value());
      else if (pick < 92)
        queue_cmd(OP_POP, SelW'($urandom), rand_value());
      else if (pick < 96)
        queue_cmd(OP_CLEAR, SelW'($urandom), rand_value());
      else
        queue_cmd(OP_UNUSED, SelW'($urandom), rand_value());
    end
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        predict_reply(cmd);
        if (burst_left > 0) burst_left--;
      end
      if (!cmd_valid || cmd_ready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (cmd_pending.size() != 0) begin
          cmd       <= cmd_pending.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changes mode now and then, plus one long hold-off
  int  mode_left = 0;
  int  ready_mode = 0;
  int  holdoff_left = 0;
  bit  holdoff_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      rsp_ready    <= 1'b0;
    end else if (!holdoff_done && beats_seen >= 60) begin
      holdoff_done <= 1'b1;
      holdoff_left <= 300;
      rsp_ready    <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      case (ready_mode)
        0:       rsp_ready <= 1'b1;
        1:       rsp_ready <= 1'($urandom_range(0, 1));
        2:       rsp_ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor: compare each response beat with the oldest expected reply
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      beats_seen++;
      if (reply_expected.size() == 0) begin
        $error("response beat with nothing expected: %p", rsp);
        fail_count++;
      end else begin
        want = reply_expected.pop_front();
        if (rsp.success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, rsp.success);
          fail_count++;
        end
        if (rsp.pop_value !== want.pop_value) begin
          $error("pop_value: expected 0x%08h, got 0x%08h", want.pop_value, rsp.pop_value);
          fail_count++;
        end
        if (rsp.response_word !== want.response_word) begin
          $error("response_word: expected 0x%08h, got 0x%08h",
                 want.response_word, rsp.response_word);
          fail_count++;
        end
      end
    end
  end

  // safety net on the run length
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int fill_sel;
    int run_len;

    for (int i = 0; i < NumStacks; i++) shadow_depth[i] = 0;

    // directed: extremes of value and select, every operation, empty pops,
    // the unused code and a clear with stacks still holding entries
    queue_cmd(OP_PUSH, 2'd0, '0);
    queue_cmd(OP_PUSH, 2'd0, '1);
    queue_cmd(OP_PUSH, 2'd1, 30'h2AAA_AAAA);
    queue_cmd(OP_PUSH, 2'd2, 30'h1555_5555);
    queue_cmd(OP_PUSH, 2'd3, 30'h0000_0001);
    queue_cmd(OP_POP,  2'd0, '1);
    queue_cmd(OP_POP,  2'd0, '0);
    queue_cmd(OP_POP,  2'd0, '0);
    queue_cmd(OP_POP,  2'd1, '0);
    queue_cmd(OP_POP,  2'd1, '0);
    queue_cmd(OP_UNUSED, 2'd2, '1);
    queue_cmd(OP_POP,  2'd2, '0);
    queue_cmd(OP_PUSH, 2'd3, 30'h2000_0000);
    queue_cmd(OP_PUSH, 2'd2, '1);
    queue_cmd(OP_CLEAR, 2'd3, '1);
    queue_cmd(OP_POP,  2'd3, '0);
    queue_cmd(OP_POP,  2'd2, '0);
    queue_cmd(OP_PUSH, 2'd3, '1);
    queue_cmd(OP_POP,  2'd3, '0);
    queue_cmd(OP_POP,  2'd3, '1);

    // random: free mixes and deep push runs unwound in LIFO order
    while (cmd_pending.size() < 40) begin
      if ($urandom_range(0, 2) == 0) begin
        fill_sel = $urandom_range(0, NumStacks - 1);
        run_len  = $urandom_range(10, 60);
        for (int i = 0; i < run_len; i++)
          queue_cmd(OP_PUSH, SelW'(fill_sel), rand_value());
        add_random_mix($urandom_range(0, 6));
        for (int i = 0; i < run_len + 2; i++)
          queue_cmd(OP_POP, SelW'(fill_sel), rand_value());
      end else begin
        add_random_mix($urandom_range(5, 30));
      end
    end

    // fill one stack past its depth, refuse, make room, refill, then clear
    fill_sel = $urandom_range(0, NumStacks - 1);
    queue_cmd(OP_CLEAR, SelW'($urandom), rand_value());
    for (int i = 0; i < StackDepth + 3; i++)
      queue_cmd(OP_PUSH, SelW'(fill_sel), rand_value());
    for (int i = 0; i < 3; i++)
      queue_cmd(OP_POP, SelW'(fill_sel), rand_value());
    for (int i = 0; i < 4; i++)
      queue_cmd(OP_PUSH, SelW'(fill_sel), rand_value());
    for (int i = 0; i < NumStacks; i++)
      queue_cmd(OP_PUSH, SelW'(i), rand_value());
    queue_cmd(OP_CLEAR, SelW'($urandom), rand_value());
    queue_cmd(OP_PUSH, SelW'(fill_sel), rand_value());
    queue_cmd(OP_POP, SelW'(fill_sel), rand_value());
    queue_cmd(OP_POP, SelW'(fill_sel), rand_value());
    add_random_mix(20);

    // reset held, then released
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // wait for every beat to go in and every reply to come out
    while (cmd_pending.size() != 0 || cmd_valid || reply_expected.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (reply_expected.size() != 0) begin
      $error("%0d expected replies never arrived", reply_expected.size());
      fail_count++;
    end

    $display("covered %0d pushes (%0d refused on a full stack), %0d pops (%0d on empty)",
             n_push_ok + n_push_full, n_push_full, n_pop_ok + n_pop_empty, n_pop_empty);
    $display("plus %0d clears and %0d unused-code commands; %0d response beats checked",
             n_clear, n_ignored, beats_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fwsm_pkg.sv
rtl/fwsm_store.sv
rtl/four_way_stack_manager.sv
rtl/fwsm_chk.sv
sim/four_way_stack_manager_test.sv
